// ===== rtl/core/cst_pkg.sv =====
// Shared constants, codes and the result record for the connection slot table.
package cst_pkg;

    // Table size and run limit.
    localparam int NUM_SLOTS   = 4;
    localparam int MAX_RESULTS = 4;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int FCNT_W      = $clog2(NUM_SLOTS + 1);
    localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

    // Field widths.
    localparam int REQ_W      = 4;
    localparam int ADDR_W     = 48;
    localparam int KIND_W     = 2;
    localparam int IDX_W      = 2;
    localparam int REASON_W   = 17;
    localparam int MTU_W      = 16;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 2;
    localparam int FREE_W     = 3;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 96;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_CONNECT        = 4'd0;
    localparam logic [REQ_W-1:0] REQ_ISSUE_FAIL     = 4'd1;
    localparam logic [REQ_W-1:0] REQ_CONNECTED      = 4'd2;
    localparam logic [REQ_W-1:0] REQ_CONNECT_FAIL   = 4'd3;
    localparam logic [REQ_W-1:0] REQ_DISCONNECT     = 4'd4;
    localparam logic [REQ_W-1:0] REQ_DISCONNECTED   = 4'd5;
    localparam logic [REQ_W-1:0] REQ_DISCONNECT_ALL = 4'd6;
    localparam logic [REQ_W-1:0] REQ_LOOKUP         = 4'd7;
    localparam logic [REQ_W-1:0] REQ_LIST           = 4'd8;

    // Slot states.
    typedef logic [1:0] slot_state_t;
    localparam slot_state_t ST_FREE          = 2'd0;
    localparam slot_state_t ST_CONNECTING    = 2'd1;
    localparam slot_state_t ST_CONNECTED     = 2'd2;
    localparam slot_state_t ST_DISCONNECTING = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STS_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] STS_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STS_STALE     = 3'd3;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd4;

    localparam logic [REASON_W-1:0] REASON_ISSUE_FAIL = '1;

    // One result without the free count and the last mark.
    typedef struct packed {
        logic                  lookup_connected;
        logic [MTU_W-1:0]      mtu;
        logic [REASON_W-1:0]   reason;
        logic                  notify_success;
        logic                  notify;
        logic [ADDR_W-1:0]     address;
        logic [SLOT_OUT_W-1:0] slot;
        logic [STATUS_W-1:0]   status;
    } result_t;

endpackage

// ===== rtl/core/connection_slot_table.sv =====
// Connection slot table: slot storage, scan sequencer and result output register.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  s_      | in        | s_tvalid/s_tready | s_tuser request code, s_tdata event fields
//  m_      | out       | m_tvalid/m_tready | m_tdata result fields, m_tlast end of run
//
// An item is taken, then a single 48-bit address comparator walks the slots one per cycle,
// and a final phase commits the table update and loads the last result. Connect,
// disconnect, lookup, list and disconnect-all walk every slot; slot events read only the
// indexed slot, and unknown codes and out-of-range slot events skip the walk. A list or
// disconnect-all walk stalls while a result is held back and the output register is full.
// Input is taken only while the sequencer is idle. A full output register holds the
// walk until the downstream side takes its item. Reset frees all slots at once.
module connection_slot_table
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata, lowest bit first: peer_address, peer_addr_type, slot_index,
    // event_reason, link_mtu, zero fill
    input  logic [cst_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: req_type
    input  logic [cst_pkg::REQ_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata, lowest bit first: status, slot_out, address_out, notify,
    // notify_success, reason_out, mtu_out, free_count, lookup_connected, zero fill
    output logic [cst_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import cst_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SCAN = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    localparam int RES_W = $bits(result_t);

    // Sequencer phase.
    logic [1:0]          phase_reg, phase_next;

    // Latched request.
    logic [REQ_W-1:0]    req_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [REASON_W-1:0] reason_reg;
    logic [MTU_W-1:0]    mtu_reg;

    // Walk pointer and what the walk found.
    logic [SLOT_W-1:0]   ptr_reg, ptr_next;
    logic                hit_found_reg, hit_found_next;
    logic [SLOT_W-1:0]   hit_idx_reg, hit_idx_next;
    slot_state_t         hit_state_reg, hit_state_next;
    logic [ADDR_W-1:0]   hit_addr_reg, hit_addr_next;
    logic                free_found_reg, free_found_next;
    logic [SLOT_W-1:0]   free_idx_reg, free_idx_next;

    // Run results of list and disconnect-all: one result is held back until it is known
    // whether another follows.
    logic [RCNT_W-1:0]   emit_cnt_reg, emit_cnt_next;
    logic                pend_valid_reg, pend_valid_next;
    result_t             pend_reg, pend_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;
    logic                out_last_reg, out_last_next;
    logic [FREE_W-1:0]   out_free_reg, out_free_next;

    // Slot table.
    slot_state_t         slot_state_reg [NUM_SLOTS];
    logic [ADDR_W-1:0]   slot_addr_reg  [NUM_SLOTS];
    logic [KIND_W-1:0]   slot_kind_reg  [NUM_SLOTS];
    logic [FCNT_W-1:0]   free_cnt_reg, free_cnt_next;

    // Single write port into the table.
    logic                wr_en;
    logic                wr_addr_en;
    logic [SLOT_W-1:0]   wr_idx;
    slot_state_t         wr_state;
    logic [ADDR_W-1:0]   wr_addr;
    logic [KIND_W-1:0]   wr_kind;

    // Shared comparator and walk helpers.
    slot_state_t         cur_state;
    logic [ADDR_W-1:0]   cur_addr;
    logic                addr_eq;
    logic                last_slot;
    logic                out_can_load;
    logic                ev_ok;
    logic                in_accept;
    logic                visiting;
    logic                stall;
    result_t             run_res;
    result_t             fin_res;
    logic                fin_free_inc;
    logic                fin_free_dec;

    logic [REQ_W-1:0]    in_req;
    logic [IDX_W-1:0]    in_idx;
    logic                in_ev_ok;

    assign in_req   = s_tuser;
    assign in_idx   = s_tdata[51:50];
    assign in_ev_ok = 32'(in_idx) < 32'(NUM_SLOTS);

    assign s_tready  = (phase_reg == PH_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign cur_state    = slot_state_reg[ptr_reg];
    assign cur_addr     = slot_addr_reg[ptr_reg];
    assign addr_eq      = (cur_addr == addr_reg);
    assign last_slot    = (ptr_reg == SLOT_W'(NUM_SLOTS - 1));
    assign out_can_load = !out_valid_reg || m_tready;
    assign ev_ok        = 32'(idx_reg) < 32'(NUM_SLOTS);

    // A run result is made for each slot in use until the result limit is reached.
    assign visiting = (cur_state != ST_FREE) && (32'(emit_cnt_reg) < 32'(MAX_RESULTS));
    assign stall    = visiting && pend_valid_reg && !out_can_load;

    always_comb
    begin
        run_res         = '0;
        run_res.slot    = SLOT_OUT_W'(ptr_reg);
        run_res.address = cur_addr;
        if ((req_reg == REQ_LIST) || (cur_state == ST_CONNECTED))
        begin
            run_res.status = STS_OK;
        end
        else
        begin
            run_res.status = STS_NOT_FOUND;
        end
    end

    // Final result of the item and the table update that goes with it.
    always_comb
    begin
        fin_res      = '0;
        fin_free_inc = 1'b0;
        fin_free_dec = 1'b0;
        wr_en        = 1'b0;
        wr_addr_en   = 1'b0;
        wr_idx       = SLOT_W'(idx_reg);
        wr_state     = ST_FREE;
        wr_addr      = '0;
        wr_kind      = '0;

        unique case (req_reg) inside
            REQ_CONNECT:
            begin
                fin_res.address = addr_reg;
                if (hit_found_reg)
                begin
                    fin_res.status = STS_DUPLICATE;
                    fin_res.slot   = SLOT_OUT_W'(hit_idx_reg);
                end
                else if (!free_found_reg)
                begin
                    fin_res.status = STS_FULL;
                end
                else
                begin
                    fin_res.status = STS_OK;
                    fin_res.slot   = SLOT_OUT_W'(free_idx_reg);
                    fin_free_dec   = 1'b1;
                    wr_en          = 1'b1;
                    wr_addr_en     = 1'b1;
                    wr_idx         = free_idx_reg;
                    wr_state       = ST_CONNECTING;
                    wr_addr        = addr_reg;
                    wr_kind        = kind_reg;
                end
            end
            REQ_ISSUE_FAIL, REQ_CONNECT_FAIL, REQ_DISCONNECTED:
            begin
                fin_res.slot = SLOT_OUT_W'(idx_reg);
                if (!ev_ok || (hit_state_reg == ST_FREE))
                begin
                    fin_res.status  = STS_STALE;
                    fin_res.address = ev_ok ? hit_addr_reg : '0;
                end
                else
                begin
                    // The slot is released and cleared, and the event is reported with its reason.
                    fin_res.status  = STS_OK;
                    fin_res.address = hit_addr_reg;
                    fin_res.notify  = 1'b1;
                    fin_res.reason  = (req_reg == REQ_ISSUE_FAIL) ? REASON_ISSUE_FAIL
                                                                  : reason_reg;
                    fin_free_inc    = 1'b1;
                    wr_en           = 1'b1;
                    wr_addr_en      = 1'b1;
                end
            end
            REQ_CONNECTED:
            begin
                fin_res.slot    = SLOT_OUT_W'(idx_reg);
                fin_res.address = ev_ok ? hit_addr_reg : '0;
                if (!ev_ok || (hit_state_reg != ST_CONNECTING))
                begin
                    fin_res.status = STS_STALE;
                end
                else
                begin
                    fin_res.status         = STS_OK;
                    fin_res.notify         = 1'b1;
                    fin_res.notify_success = 1'b1;
                    fin_res.mtu            = mtu_reg;
                    wr_en                  = 1'b1;
                    wr_state               = ST_CONNECTED;
                end
            end
            REQ_DISCONNECT:
            begin
                fin_res.address = addr_reg;
                fin_res.slot    = hit_found_reg ? SLOT_OUT_W'(hit_idx_reg) : '0;
                if (hit_found_reg && (hit_state_reg == ST_CONNECTED))
                begin
                    fin_res.status = STS_OK;
                    wr_en          = 1'b1;
                    wr_idx         = hit_idx_reg;
                    wr_state       = ST_DISCONNECTING;
                end
                else
                begin
                    fin_res.status = STS_NOT_FOUND;
                end
            end
            REQ_LOOKUP:
            begin
                fin_res.address = addr_reg;
                if (hit_found_reg)
                begin
                    fin_res.status           = STS_OK;
                    fin_res.slot             = SLOT_OUT_W'(hit_idx_reg);
                    fin_res.lookup_connected = (hit_state_reg == ST_CONNECTED);
                end
                else
                begin
                    fin_res.status = STS_NOT_FOUND;
                end
            end
            REQ_LIST, REQ_DISCONNECT_ALL:
            begin
                // The held-back result closes the run; an empty run reports not found.
                if (pend_valid_reg)
                begin
                    fin_res = pend_reg;
                end
                else
                begin
                    fin_res.status = STS_NOT_FOUND;
                end
            end
            default:
            begin
                fin_res.status  = STS_NOT_FOUND;
                fin_res.address = addr_reg;
            end
        endcase

        // Disconnect-all marks connected slots as the walk passes them.
        if ((phase_reg == PH_SCAN) && (req_reg == REQ_DISCONNECT_ALL) && visiting &&
            !stall && (cur_state == ST_CONNECTED))
        begin
            wr_en      = 1'b1;
            wr_addr_en = 1'b0;
            wr_idx     = ptr_reg;
            wr_state   = ST_DISCONNECTING;
        end
        else if (!((phase_reg == PH_DONE) && out_can_load))
        begin
            wr_en      = 1'b0;
            wr_addr_en = 1'b0;
        end
    end

    // Sequencer.
    always_comb
    begin
        phase_next      = phase_reg;
        ptr_next        = ptr_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_state_next  = hit_state_reg;
        hit_addr_next   = hit_addr_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        emit_cnt_next   = emit_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_free_next   = out_free_reg;
        free_cnt_next   = free_cnt_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_accept)
                begin
                    ptr_next        = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    emit_cnt_next   = '0;
                    pend_valid_next = 1'b0;
                    phase_next      = PH_SCAN;
                    unique case (in_req) inside
                        REQ_ISSUE_FAIL, REQ_CONNECTED, REQ_CONNECT_FAIL, REQ_DISCONNECTED:
                        begin
                            if (in_ev_ok)
                            begin
                                ptr_next = SLOT_W'(in_idx);
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        REQ_CONNECT, REQ_DISCONNECT, REQ_LOOKUP, REQ_LIST,
                        REQ_DISCONNECT_ALL:
                        begin
                            phase_next = PH_SCAN;
                        end
                        default:
                        begin
                            phase_next = PH_DONE;
                        end
                    endcase
                end
            end
            PH_SCAN:
            begin
                unique case (req_reg) inside
                    REQ_ISSUE_FAIL, REQ_CONNECTED, REQ_CONNECT_FAIL, REQ_DISCONNECTED:
                    begin
                        hit_state_next = cur_state;
                        hit_addr_next  = cur_addr;
                        phase_next     = PH_DONE;
                    end
                    REQ_LIST, REQ_DISCONNECT_ALL:
                    begin
                        if (!stall)
                        begin
                            if (visiting)
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_valid_next = 1'b1;
                                    out_next       = pend_reg;
                                    out_last_next  = 1'b0;
                                    out_free_next  = FREE_W'(free_cnt_reg);
                                end
                                pend_valid_next = 1'b1;
                                pend_next       = run_res;
                                emit_cnt_next   = emit_cnt_reg + RCNT_W'(1);
                            end
                            if (last_slot)
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                ptr_next = ptr_reg + SLOT_W'(1);
                            end
                        end
                    end
                    default:
                    begin
                        // Address search: first matching slot in use, first free slot.
                        if ((cur_state != ST_FREE) && addr_eq && !hit_found_reg)
                        begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = ptr_reg;
                            hit_state_next = cur_state;
                            hit_addr_next  = cur_addr;
                        end
                        if ((cur_state == ST_FREE) && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = ptr_reg;
                        end
                        if (last_slot)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            ptr_next = ptr_reg + SLOT_W'(1);
                        end
                    end
                endcase
            end
            PH_DONE:
            begin
                if (out_can_load)
                begin
                    free_cnt_next = free_cnt_reg + FCNT_W'(fin_free_inc)
                                    - FCNT_W'(fin_free_dec);
                    out_valid_next  = 1'b1;
                    out_next        = fin_res;
                    out_last_next   = 1'b1;
                    out_free_next   = FREE_W'(free_cnt_next);
                    pend_valid_next = 1'b0;
                    phase_next      = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            free_cnt_reg   <= FCNT_W'(NUM_SLOTS);
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_state_reg[i] <= ST_FREE;
                slot_addr_reg[i]  <= '0;
                slot_kind_reg[i]  <= '0;
            end
        end
        else
        begin
            phase_reg      <= phase_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            free_cnt_reg   <= free_cnt_next;
            if (wr_en)
            begin
                slot_state_reg[wr_idx] <= wr_state;
            end
            if (wr_addr_en)
            begin
                slot_addr_reg[wr_idx] <= wr_addr;
                slot_kind_reg[wr_idx] <= wr_kind;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg    <= in_req;
            addr_reg   <= s_tdata[47:0];
            kind_reg   <= s_tdata[49:48];
            idx_reg    <= in_idx;
            reason_reg <= s_tdata[68:52];
            mtu_reg    <= s_tdata[84:69];
        end
        ptr_reg        <= ptr_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_state_reg  <= hit_state_next;
        hit_addr_reg   <= hit_addr_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        emit_cnt_reg   <= emit_cnt_next;
        pend_reg       <= pend_next;
        out_reg        <= out_next;
        out_last_reg   <= out_last_next;
        out_free_reg   <= out_free_next;
    end

    // Output packing: the result record without the lookup flag, then the free count, then the lookup flag.
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W - RES_W - FREE_W){1'b0}},
                       out_reg.lookup_connected,
                       out_free_reg,
                       out_reg.mtu,
                       out_reg.reason,
                       out_reg.notify_success,
                       out_reg.notify,
                       out_reg.address,
                       out_reg.slot,
                       out_reg.status};

endmodule
